// ----- rtl/ps2s1_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Shared types, layout tables and lookup helpers for the scan set 1 decoder.
// ----------------------------------------------------------------------------
package ps2s1_pkg;

    localparam int TAB_LEN = 89;
    localparam int PAD_LEN = 13;

    // Scan codes of interest
    localparam logic [7:0] BYTE_E0     = 8'hE0;
    localparam logic [7:0] BYTE_E1     = 8'hE1;
    localparam logic [6:0] SC_LSHIFT   = 7'd42;
    localparam logic [6:0] SC_RSHIFT   = 7'd54;
    localparam logic [6:0] SC_ALT      = 7'd56;
    localparam logic [6:0] SC_CTRL     = 7'd29;
    localparam logic [6:0] SC_CAPS     = 7'd58;
    localparam logic [6:0] SC_SCROLL   = 7'd70;
    localparam logic [6:0] SC_NUM      = 7'd69;
    localparam logic [6:0] SC_KP_DIV   = 7'd53;
    localparam logic [6:0] SC_PAD_LO   = 7'd71;
    localparam logic [6:0] SC_PAD_HI   = 7'd83;
    localparam logic [7:0] CHAR_SLASH  = "/";
    localparam logic [6:0] DIV_CODE_RST = 7'd8;

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_E0   = 2'd1,
        PFX_E1   = 2'd2
    } t_prefix;

    typedef enum logic [1:0] {
        TBL_PLAIN = 2'd0,
        TBL_SHIFT = 2'd1,
        TBL_ALTGR = 2'd2
    } t_tbl;

    typedef struct packed {
        logic shift;
        logic alt_l;
        logic alt_r;
        logic ctrl_l;
        logic ctrl_r;
        logic caps;
        logic num;
        logic scroll;
    } t_mods;

    typedef struct packed {
        logic       key_valid;
        logic       use_ovr;
        logic [7:0] ovr_char;
        logic [6:0] scan;
        t_mods      mods;
        logic       leds;
    } t_key_info;

    localparam logic [7:0] TAB_PLAIN [TAB_LEN] = '{
        8'd0, 8'd0, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
        8'd225, 8'd39, 8'd8,
        8'd0, "q", "w", "e", "r", "t", "z", "u", "i", "o", "p", 8'd129, "+", 8'd10,
        8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", 8'd148, 8'd132, "^",
        8'd0, "#",
        "y", "x", "c", "v", "b", "n", "m", ",", ".", "-", 8'd0,
        "*", 8'd0, " ", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "-",
        8'd0, 8'd0, 8'd0, "+", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "<",
        8'd0, 8'd0
    };

    localparam logic [7:0] TAB_SHIFT [TAB_LEN] = '{
        8'd0, 8'd0, "!", 8'd34, 8'd21, "$", "%", "&", "/", "(", ")", "=", "?",
        8'd96, 8'd0,
        8'd0, "Q", "W", "E", "R", "T", "Z", "U", "I", "O", "P", 8'd154, "*", 8'd0,
        8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", 8'd153, 8'd142, 8'd248,
        8'd0, 8'd39,
        "Y", "X", "C", "V", "B", "N", "M", ";", ":", "_", 8'd0,
        8'd0, 8'd0, " ", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, ">",
        8'd0, 8'd0
    };

    localparam logic [7:0] TAB_ALTGR [TAB_LEN] = '{
        8'd0, 8'd0, 8'd0, 8'd253, 8'd0, 8'd0, 8'd0, 8'd0, "{", "[", "]", "}",
        8'd92, 8'd0, 8'd0,
        8'd0, "@", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        "~", 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd230, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "|",
        8'd0, 8'd0
    };

    localparam logic [7:0] PAD_CHAR [PAD_LEN] = '{
        "7", "8", "9", "-", "4", "5", "6", "+", "1", "2", "3", "0", ","
    };

    localparam logic [6:0] PAD_SCAN [PAD_LEN] = '{
        7'd8, 7'd9, 7'd10, 7'd53, 7'd5, 7'd6, 7'd7, 7'd27, 7'd2, 7'd3, 7'd4,
        7'd11, 7'd51
    };

    function automatic logic is_letter(input logic [6:0] code);
        return ((code >= 7'd16) && (code <= 7'd26)) ||
               ((code >= 7'd30) && (code <= 7'd40)) ||
               ((code >= 7'd44) && (code <= 7'd50));
    endfunction

    function automatic logic [7:0] char_lookup(input t_tbl sel, input logic [6:0] code);
        logic [7:0] c;
        c = 8'd0;
        if (code < 7'(TAB_LEN)) begin
            case (sel)
                TBL_PLAIN: c = TAB_PLAIN[code];
                TBL_SHIFT: c = TAB_SHIFT[code];
                TBL_ALTGR: c = TAB_ALTGR[code];
                default:   c = 8'd0;
            endcase
        end
        return c;
    endfunction

endpackage

// ----- rtl/ps2s1_char_rom.sv -----
// ----------------------------------------------------------------------------
// ps2s1_char_rom
// Synchronous layout ROM: table select and scan code in, character out from a
// register that loads while the read enable is high.
// ----------------------------------------------------------------------------
module ps2s1_char_rom
    import ps2s1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rd_en,
    input  t_tbl       i_rd_sel,
    input  logic [6:0] i_rd_code,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= char_lookup(i_rd_sel, i_rd_code);
        end
    end

    assign o_rd_data = r_data;

endmodule

// ----- rtl/ps2s1_decode.sv -----
// ----------------------------------------------------------------------------
// ps2s1_decode
// Keyboard state (prefix, modifiers, locks) and per-byte classification.
// Drives the ROM address and registers the key information on accept.
// ----------------------------------------------------------------------------
module ps2s1_decode
    import ps2s1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_scan_byte,
    input  logic [6:0] i_div_code,
    output t_tbl       o_rom_sel,
    output logic [6:0] o_rom_code,
    output t_key_info  o_info
);

    t_prefix   r_prefix, n_prefix;
    t_mods     r_mods, n_mods;
    t_key_info r_info, n_info;

    logic [6:0] code;
    logic       e0;
    logic       is_pfx;
    logic       pad_hit;
    logic [3:0] pad_idx;
    logic [6:0] pad_off;

    assign code    = i_scan_byte[6:0];
    assign e0      = (r_prefix == PFX_E0);
    assign is_pfx  = (i_scan_byte == BYTE_E0) || (i_scan_byte == BYTE_E1);
    assign pad_hit = r_mods.num && (r_prefix == PFX_NONE) &&
                     (code >= SC_PAD_LO) && (code <= SC_PAD_HI);
    assign pad_off = code - SC_PAD_LO;
    assign pad_idx = pad_off[3:0];

    // Table choice for ordinary keys
    always_comb begin
        if (r_mods.alt_r) begin
            o_rom_sel = TBL_ALTGR;
        end else if (r_mods.shift || (r_mods.caps && is_letter(code))) begin
            o_rom_sel = TBL_SHIFT;
        end else begin
            o_rom_sel = TBL_PLAIN;
        end
    end
    assign o_rom_code = code;

    always_comb begin
        n_prefix = r_prefix;
        n_mods   = r_mods;
        n_info   = '0;

        if (is_pfx) begin
            n_prefix = (i_scan_byte == BYTE_E0) ? PFX_E0 : PFX_E1;
        end else if (i_scan_byte[7]) begin
            // break: release modifiers
            if ((code == SC_LSHIFT) || (code == SC_RSHIFT)) begin
                n_mods.shift = 1'b0;
            end else if (code == SC_ALT) begin
                if (e0) n_mods.alt_r = 1'b0; else n_mods.alt_l = 1'b0;
            end else if (code == SC_CTRL) begin
                if (e0) n_mods.ctrl_r = 1'b0; else n_mods.ctrl_l = 1'b0;
            end
            n_prefix = PFX_NONE;
        end else begin
            if ((code == SC_LSHIFT) || (code == SC_RSHIFT)) begin
                n_mods.shift = 1'b1;
            end else if (code == SC_ALT) begin
                if (e0) n_mods.alt_r = 1'b1; else n_mods.alt_l = 1'b1;
            end else if (code == SC_CTRL) begin
                if (e0) n_mods.ctrl_r = 1'b1; else n_mods.ctrl_l = 1'b1;
            end else if (code == SC_CAPS) begin
                n_mods.caps = ~r_mods.caps;
                n_info.leds = 1'b1;
            end else if (code == SC_SCROLL) begin
                n_mods.scroll = ~r_mods.scroll;
                n_info.leds   = 1'b1;
            end else if ((code == SC_NUM) && !r_mods.ctrl_l) begin
                n_mods.num  = ~r_mods.num;
                n_info.leds = 1'b1;
            end else begin
                n_info.key_valid = 1'b1;
                n_info.scan      = code;
                if ((code == SC_KP_DIV) && e0) begin
                    n_info.use_ovr  = 1'b1;
                    n_info.ovr_char = CHAR_SLASH;
                    n_info.scan     = i_div_code;
                end else if (pad_hit) begin
                    n_info.use_ovr  = 1'b1;
                    n_info.ovr_char = PAD_CHAR[pad_idx];
                    n_info.scan     = PAD_SCAN[pad_idx];
                end
            end
            n_prefix = PFX_NONE;
        end
        n_info.mods = n_mods;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= PFX_NONE;
            r_mods   <= '0;
        end else if (i_accept) begin
            r_prefix <= n_prefix;
            r_mods   <= n_mods;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_info <= n_info;
        end
    end

    assign o_info = r_info;

endmodule

// ----- rtl/ps2s1_out_stage.sv -----
// ----------------------------------------------------------------------------
// ps2s1_out_stage
// Lookup and output stages: merges the ROM character with the key
// information and holds the finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module ps2s1_out_stage
    import ps2s1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_key_info  i_info,
    input  logic [7:0] i_rom_data,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_key_info  o_item,
    output logic [7:0] o_ascii
);

    logic       r_a_valid;
    logic       r_b_valid;
    t_key_info  r_b_info;
    logic [7:0] r_b_ascii;
    logic [7:0] n_b_ascii;
    logic       a_fire;

    assign a_fire     = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || !r_b_valid || i_out_ready;

    always_comb begin
        if (!i_info.key_valid) begin
            n_b_ascii = 8'd0;
        end else if (i_info.use_ovr) begin
            n_b_ascii = i_info.ovr_char;
        end else begin
            n_b_ascii = i_rom_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_b_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_info  <= i_info;
            r_b_ascii <= n_b_ascii;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_item      = r_b_info;
    assign o_ascii     = r_b_ascii;

endmodule

// ----- rtl/ps2s1_output_unused_guard.sv -----
// ----------------------------------------------------------------------------
// ps2s1_cfg_reg
// Configuration register holding the keypad divide scan code.
// ----------------------------------------------------------------------------
module ps2s1_cfg_reg
    import ps2s1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [6:0] i_cfg_data,
    output logic       o_cfg_ready,
    output logic [6:0] o_div_code
);

    logic [6:0] r_div_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_code <= DIV_CODE_RST;
        end else if (i_cfg_valid) begin
            r_div_code <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_div_code  = r_div_code;

endmodule

// ----- rtl/ps2_scancode_set1_to_ascii_top.sv -----
// ----------------------------------------------------------------------------
// ps2_scancode_set1_to_ascii_top
// PS/2 scan set 1 keyboard decoder with a German character layout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_in_valid / o_in_ready carry one raw keyboard byte
//                    (i_scan_byte) per item.
//   Output channel : o_out_valid / i_out_ready carry one result item per input
//                    item: key valid, character, scan code, flags, LED change.
//   Config channel : i_cfg_valid / o_cfg_ready write the keypad divide scan
//                    code; always ready. Write it only while nothing is in flight.
//   Stages         : classify the byte and read the ROM at the input accept;
//                    merge the character into the output register when the
//                    lookup stage moves on, which waits while the output holds.
//   Throughput     : one item per cycle while the output is taken; keyboard state is updated at accept.
//   Stall          : a held output item keeps its payload; one more item waits
//                    in the lookup stage, after which o_in_ready drops.
//   Reset          : synchronous, active low. Clears prefix, modifiers, locks
//                    and both pipeline stages; restores the divide code default.
// ----------------------------------------------------------------------------
module ps2_scancode_set1_to_ascii_top
    import ps2s1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_keypad_divide_code,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_scan_byte,
    // result items
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_key_valid,
    output logic [7:0] o_ascii_code,
    output logic [6:0] o_key_scancode,
    output logic       o_shift_flag,
    output logic       o_alt_left_flag,
    output logic       o_alt_right_flag,
    output logic       o_ctrl_left_flag,
    output logic       o_ctrl_right_flag,
    output logic       o_caps_flag,
    output logic       o_num_flag,
    output logic       o_scroll_flag,
    output logic       o_leds_changed
);

    logic       in_accept;
    logic [6:0] div_code;
    t_tbl       rom_sel;
    logic [6:0] rom_code;
    logic [7:0] rom_data;
    t_key_info  stage_info;
    t_key_info  out_item;
    logic [7:0] out_ascii;

    assign in_accept = i_in_valid && o_in_ready;

    // Divide key scan code register
    ps2s1_cfg_reg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_keypad_divide_code),
        .o_cfg_ready (o_cfg_ready),
        .o_div_code  (div_code)
    );

    // Classify the byte, update keyboard state, address the ROM
    ps2s1_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_scan_byte (i_scan_byte),
        .i_div_code  (div_code),
        .o_rom_sel   (rom_sel),
        .o_rom_code  (rom_code),
        .o_info      (stage_info)
    );

    // Layout ROM, read in step with the decode register
    ps2s1_char_rom u_rom (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_sel  (rom_sel),
        .i_rd_code (rom_code),
        .o_rd_data (rom_data)
    );

    // Merge and hold the result item
    ps2s1_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_info      (stage_info),
        .i_rom_data  (rom_data),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_item      (out_item),
        .o_ascii     (out_ascii)
    );

    assign o_key_valid       = out_item.key_valid;
    assign o_ascii_code      = out_ascii;
    assign o_key_scancode    = out_item.scan;
    assign o_shift_flag      = out_item.mods.shift;
    assign o_alt_left_flag   = out_item.mods.alt_l;
    assign o_alt_right_flag  = out_item.mods.alt_r;
    assign o_ctrl_left_flag  = out_item.mods.ctrl_l;
    assign o_ctrl_right_flag = out_item.mods.ctrl_r;
    assign o_caps_flag       = out_item.mods.caps;
    assign o_num_flag        = out_item.mods.num;
    assign o_scroll_flag     = out_item.mods.scroll;
    assign o_leds_changed    = out_item.leds;

    // A non-key item carries no character and no scan code
    a_nokey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_key_valid) |-> (o_ascii_code == 8'd0 && o_key_scancode == 7'd0))
        else $error("non-key item with character or scan code");

    // An LED update and a key press never come from the same byte
    a_leds_nokey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_leds_changed) |-> !o_key_valid)
        else $error("LED change reported together with a key");

    // An accepted byte must reach an idle, ready output register through the lookup stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !o_out_valid && i_out_ready) |=> ##1 o_out_valid)
        else $error("result item not delivered after two cycles");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scan set 1 keyboard decoder. A behavioural
// copy of the keyboard state (prefix, modifiers, locks, divide code) predicts
// every result item; a checker compares each accepted result field by field.
// Directed key sequences come first, then random keystrokes under several
// idling mixes, with a long output stall to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2s1_pkg::*;

    localparam int LAYOUT_LEN = 89;

    // German layout, unshifted and shifted, indexed by make code
    localparam logic [7:0] LAYOUT_PLAIN [LAYOUT_LEN] = '{
        8'd0, 8'd0, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
        8'd225, 8'd39, 8'd8,
        8'd0, "q", "w", "e", "r", "t", "z", "u", "i", "o", "p", 8'd129, "+", 8'd10,
        8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", 8'd148, 8'd132, "^",
        8'd0, "#",
        "y", "x", "c", "v", "b", "n", "m", ",", ".", "-", 8'd0,
        "*", 8'd0, " ",
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "-",
        8'd0, 8'd0, 8'd0, "+", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "<",
        8'd0, 8'd0
    };

    localparam logic [7:0] LAYOUT_SHIFT [LAYOUT_LEN] = '{
        8'd0, 8'd0, "!", 8'd34, 8'd21, "$", "%", "&", "/", "(", ")", "=", "?",
        8'd96, 8'd0,
        8'd0, "Q", "W", "E", "R", "T", "Z", "U", "I", "O", "P", 8'd154, "*", 8'd0,
        8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", 8'd153, 8'd142, 8'd248,
        8'd0, 8'd39,
        "Y", "X", "C", "V", "B", "N", "M", ";", ":", "_", 8'd0,
        8'd0, 8'd0, " ",
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, ">",
        8'd0, 8'd0
    };

    // Keypad 7..Del with num lock on: character and the digit-row code reported
    localparam logic [7:0] KEYPAD_CHARS [13] = '{
        "7", "8", "9", "-", "4", "5", "6", "+", "1", "2", "3", "0", ","
    };
    localparam logic [6:0] KEYPAD_CODES [13] = '{
        7'd8, 7'd9, 7'd10, 7'd53, 7'd5, 7'd6, 7'd7, 7'd27, 7'd2, 7'd3, 7'd4,
        7'd11, 7'd51
    };

    typedef struct packed {
        logic       key_valid;
        logic [7:0] ascii_code;
        logic [6:0] key_scancode;
        logic       shift;
        logic       alt_l;
        logic       alt_r;
        logic       ctrl_l;
        logic       ctrl_r;
        logic       caps;
        logic       num;
        logic       scroll;
        logic       leds;
    } t_key_result;

    typedef struct {
        t_prefix pfx;
        bit      shift;
        bit      alt_l;
        bit      alt_r;
        bit      ctrl_l;
        bit      ctrl_r;
        bit      caps;
        bit      num;
        bit      scroll;
    } t_kbd_state;

    // DUT ports; every input starts at a known value
    logic       i_clk                = 1'b0;
    logic       i_rst_n              = 1'b0;
    logic       i_cfg_valid          = 1'b0;
    logic       o_cfg_ready;
    logic [6:0] i_keypad_divide_code = '0;
    logic       i_in_valid           = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_scan_byte          = '0;
    logic       o_out_valid;
    logic       i_out_ready          = 1'b0;
    logic       o_key_valid;
    logic [7:0] o_ascii_code;
    logic [6:0] o_key_scancode;
    logic       o_shift_flag;
    logic       o_alt_left_flag;
    logic       o_alt_right_flag;
    logic       o_ctrl_left_flag;
    logic       o_ctrl_right_flag;
    logic       o_caps_flag;
    logic       o_num_flag;
    logic       o_scroll_flag;
    logic       o_leds_changed;

    // Bench state
    t_kbd_state  kbd;
    logic [6:0]  divide_code;
    t_key_result awaited_keys [$];
    int          n_errors   = 0;
    int          items_sent = 0;
    int          gap_pct    = 0;
    int          stall_pct  = 0;
    int          hold_left  = 0;

    ps2_scancode_set1_to_ascii_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_keypad_divide_code (i_keypad_divide_code),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_scan_byte          (i_scan_byte),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_key_valid          (o_key_valid),
        .o_ascii_code         (o_ascii_code),
        .o_key_scancode       (o_key_scancode),
        .o_shift_flag         (o_shift_flag),
        .o_alt_left_flag      (o_alt_left_flag),
        .o_alt_right_flag     (o_alt_right_flag),
        .o_ctrl_left_flag     (o_ctrl_left_flag),
        .o_ctrl_right_flag    (o_ctrl_right_flag),
        .o_caps_flag          (o_caps_flag),
        .o_num_flag           (o_num_flag),
        .o_scroll_flag        (o_scroll_flag),
        .o_leds_changed       (o_leds_changed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Keyboard model
    // ------------------------------------------------------------------------

    // Letters are the three alphabetic rows, umlauts included
    function automatic bit is_alpha_code(input logic [6:0] code);
        return (code inside {[7'd16:7'd26], [7'd30:7'd40], [7'd44:7'd50]});
    endfunction

    // AltGr layer: only a handful of keys carry a character
    function automatic logic [7:0] altgr_char(input logic [6:0] code);
        case (code)
            7'd3:    return 8'd253;
            7'd8:    return "{";
            7'd9:    return "[";
            7'd10:   return "]";
            7'd11:   return "}";
            7'd12:   return 8'd92;
            7'd16:   return "@";
            7'd27:   return "~";
            7'd50:   return 8'd230;
            7'd86:   return "|";
            default: return 8'd0;
        endcase
    endfunction

    // Advance the keyboard state by one byte and return the result it gives
    function automatic t_key_result predict_key(input logic [7:0] scan);
        t_key_result r;
        logic [6:0]  code;
        logic [3:0]  pad_idx;
        bit          was_e0;
        r       = '0;
        code    = scan[6:0];
        pad_idx = 4'(code - SC_PAD_LO);
        was_e0  = (kbd.pfx == PFX_E0);
        if (scan == BYTE_E0 || scan == BYTE_E1) begin
            // a new prefix replaces whatever was pending
            kbd.pfx = (scan == BYTE_E0) ? PFX_E0 : PFX_E1;
        end else if (scan[7]) begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                kbd.shift = 1'b0;
            end else if (code == SC_ALT) begin
                if (was_e0) kbd.alt_r = 1'b0; else kbd.alt_l = 1'b0;
            end else if (code == SC_CTRL) begin
                if (was_e0) kbd.ctrl_r = 1'b0; else kbd.ctrl_l = 1'b0;
            end
            kbd.pfx = PFX_NONE;
        end else begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                kbd.shift = 1'b1;
            end else if (code == SC_ALT) begin
                if (was_e0) kbd.alt_r = 1'b1; else kbd.alt_l = 1'b1;
            end else if (code == SC_CTRL) begin
                if (was_e0) kbd.ctrl_r = 1'b1; else kbd.ctrl_l = 1'b1;
            end else if (code == SC_CAPS) begin
                kbd.caps = !kbd.caps;
                r.leds   = 1'b1;
            end else if (code == SC_SCROLL) begin
                kbd.scroll = !kbd.scroll;
                r.leds     = 1'b1;
            end else if (code == SC_NUM && !kbd.ctrl_l) begin
                kbd.num = !kbd.num;
                r.leds  = 1'b1;
            end else begin
                // complete key; left ctrl + num lock lands here as Pause
                r.key_valid    = 1'b1;
                r.key_scancode = code;
                if (code == SC_KP_DIV && was_e0) begin
                    r.ascii_code   = "/";
                    r.key_scancode = divide_code;
                end else if (kbd.num && kbd.pfx == PFX_NONE &&
                             code >= SC_PAD_LO && code <= SC_PAD_HI) begin
                    r.ascii_code   = KEYPAD_CHARS[pad_idx];
                    r.key_scancode = KEYPAD_CODES[pad_idx];
                end else if (kbd.alt_r) begin
                    r.ascii_code = altgr_char(code);
                end else if (code >= 7'(LAYOUT_LEN)) begin
                    r.ascii_code = 8'd0;
                end else if (kbd.shift || (kbd.caps && is_alpha_code(code))) begin
                    r.ascii_code = LAYOUT_SHIFT[code];
                end else begin
                    r.ascii_code = LAYOUT_PLAIN[code];
                end
            end
            kbd.pfx = PFX_NONE;
        end
        r.shift  = kbd.shift;
        r.alt_l  = kbd.alt_l;
        r.alt_r  = kbd.alt_r;
        r.ctrl_l = kbd.ctrl_l;
        r.ctrl_r = kbd.ctrl_r;
        r.caps   = kbd.caps;
        r.num    = kbd.num;
        r.scroll = kbd.scroll;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and receiver
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    function automatic void check_key_result();
        t_key_result e;
        if (awaited_keys.size() == 0) begin
            $error("result item arrived with none expected");
            n_errors++;
            return;
        end
        e = awaited_keys.pop_front();
        check_field("key_valid",       8'(e.key_valid),    8'(o_key_valid));
        check_field("ascii_code",      e.ascii_code,       o_ascii_code);
        check_field("key_scancode",    8'(e.key_scancode), 8'(o_key_scancode));
        check_field("shift_flag",      8'(e.shift),        8'(o_shift_flag));
        check_field("alt_left_flag",   8'(e.alt_l),        8'(o_alt_left_flag));
        check_field("alt_right_flag",  8'(e.alt_r),        8'(o_alt_right_flag));
        check_field("ctrl_left_flag",  8'(e.ctrl_l),       8'(o_ctrl_left_flag));
        check_field("ctrl_right_flag", 8'(e.ctrl_r),       8'(o_ctrl_right_flag));
        check_field("caps_flag",       8'(e.caps),         8'(o_caps_flag));
        check_field("num_flag",        8'(e.num),          8'(o_num_flag));
        check_field("scroll_flag",     8'(e.scroll),       8'(o_scroll_flag));
        check_field("leds_changed",    8'(e.leds),         8'(o_leds_changed));
    endfunction

    // Check at each accepted result, then pick ready for the next edge.
    // A long hold is counted down here; the test arms it off the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            check_key_result();
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one byte, idling first at the current sender rate; predict on accept
    task automatic send_item(input logic [7:0] scan);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_scan_byte <= scan;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        awaited_keys.push_back(predict_key(scan));
        items_sent++;
    endtask

    // Drop valid and hold off until every result is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_keys.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_divide_code(input logic [6:0] value);
        wait_idle();
        i_cfg_valid          <= 1'b1;
        i_keypad_divide_code <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        divide_code = value;
    endtask

    task automatic send_bytes(input logic [7:0] seq [$]);
        foreach (seq[k]) send_item(seq[k]);
    endtask

    // One random keystroke; mostly well-formed sequences, some raw noise
    task automatic play_keystroke();
        int         kind;
        bit         ext;
        logic [6:0] code;
        kind = $urandom_range(99);
        ext  = ($urandom_range(3) == 0);
        if (kind < 25) begin
            // any key, tapped or just pressed
            code = 7'($urandom_range(127));
            if (ext) send_item(BYTE_E0);
            send_item({1'b0, code});
            if ($urandom_range(1)) begin
                if (ext) send_item(BYTE_E0);
                send_item({1'b1, code});
            end
        end else if (kind < 45) begin
            // modifier press or release, left or right
            case ($urandom_range(3))
                0:       code = SC_LSHIFT;
                1:       code = SC_RSHIFT;
                2:       code = SC_ALT;
                default: code = SC_CTRL;
            endcase
            if (ext) send_item(BYTE_E0);
            send_item({1'($urandom_range(1)), code});
        end else if (kind < 55) begin
            case ($urandom_range(2))
                0:       code = SC_CAPS;
                1:       code = SC_SCROLL;
                default: code = SC_NUM;
            endcase
            send_item({1'b0, code});
            send_item({1'b1, code});
        end else if (kind < 67) begin
            // keypad block, divide included
            if ($urandom_range(4) == 0) begin
                code = SC_KP_DIV;
                ext  = ($urandom_range(3) != 0);
            end else begin
                code = 7'($urandom_range(SC_PAD_HI, SC_PAD_LO));
            end
            if (ext) send_item(BYTE_E0);
            send_item({1'b0, code});
            if (ext) send_item(BYTE_E0);
            send_item({1'b1, code});
        end else if (kind < 71) begin
            // Pause as the keyboard sends it
            send_bytes('{BYTE_E1, 8'h1D, 8'h45, BYTE_E1, 8'h9D, 8'hC5});
        end else if (kind < 85) begin
            code = 7'($urandom_range(50, 16));
            send_item({1'b0, code});
            send_item({1'b1, code});
        end else begin
            send_item(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero code, top code, top break
    task automatic test_field_extremes();
        send_bytes('{8'h00, 8'h7F, 8'hFF});
    endtask

    // Divide key after E0; a later prefix replaces a pending one
    task automatic test_prefixes();
        send_bytes('{BYTE_E0, 8'h35, BYTE_E0, BYTE_E1, 8'h35});
    endtask

    // Shift layer, then AltGr layer with the right alt held
    task automatic test_modifier_layers();
        send_bytes('{8'h2A, 8'h1E, 8'hAA, BYTE_E0, 8'h38, 8'h10, BYTE_E0, 8'hB8});
    endtask

    // Caps shifts letters only; num lock keypad, but not after E0; scroll lock
    task automatic test_lock_keys();
        send_bytes('{8'h3A, 8'h10, 8'h02, 8'h45, 8'h47, BYTE_E0, 8'h47, 8'h46});
    endtask

    // Ctrl + num lock is reported as a key and leaves num lock alone
    task automatic test_pause_key();
        send_bytes('{8'h1D, 8'h45, 8'h9D});
    endtask

    task automatic test_divide_code_register();
        load_divide_code(7'd0);
        send_bytes('{BYTE_E0, 8'h35});
        load_divide_code(7'd127);
        send_bytes('{BYTE_E0, 8'h35});
    endtask

    // Stall the output long enough to fill both stages while bytes keep coming
    task automatic test_backpressure();
        wait_idle();
        gap_pct   = 0;
        stall_pct = 0;
        @(negedge i_clk);
        hold_left = 80;
        @(posedge i_clk);
        repeat (24) send_item(8'($urandom_range(255)));
        wait_idle();
    endtask

    task automatic run_random_phase(input int n_items, input int gap, input int stall,
                                    input logic [6:0] code);
        int start;
        load_divide_code(code);
        gap_pct   = gap;
        stall_pct = stall;
        start     = items_sent;
        while (items_sent - start < n_items) play_keystroke();
    endtask

    task automatic test_random_phases();
        run_random_phase(150, 0,  0,  7'($urandom_range(127)));
        run_random_phase(150, 69, 0,  7'($urandom_range(127)));
        run_random_phase(150, 0,  69, 7'($urandom_range(127)));
        run_random_phase(150, 11, 11, DIV_CODE_RST);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        kbd         = '{pfx: PFX_NONE, default: 1'b0};
        divide_code = DIV_CODE_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_prefixes();
        test_modifier_layers();
        test_lock_keys();
        test_pause_key();
        test_divide_code_register();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (n_errors == 0)
            $display("ps2_scancode_set1_to_ascii_top verification clean");
        else
            $display("ps2_scancode_set1_to_ascii_top verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2ms;
        $display("ps2_scancode_set1_to_ascii_top verification failed");
        $finish;
    end

endmodule
